// File: hdl/assert_macros.svh
// Assertion macros for the checker file of the keyframe curve evaluator.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/kce_pkg.sv
// Package of the keyframe curve evaluator: sizes, codes and the
// command and status words between controller and datapath. No dependencies.
`default_nettype none

package kce_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int ADDR_W    = 6;
  localparam int CNT_W     = 7;
  localparam int FRAC_BITS = 16;
  localparam int DCNT_W    = 6;

  localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  localparam logic [1:0] KIND_STEP   = 2'd0;
  localparam logic [1:0] KIND_LINEAR = 2'd1;

  localparam logic [1:0] WRAP_LOOP = 2'd1;
  localparam logic [1:0] WRAP_PING = 2'd2;

  // Datapath operations.
  localparam logic [4:0] OP_NONE       = 5'd0;
  localparam logic [4:0] OP_START      = 5'd1;
  localparam logic [4:0] OP_WRAP_SETUP = 5'd2;
  localparam logic [4:0] OP_WRAP_FIN   = 5'd3;
  localparam logic [4:0] OP_LATCH_L    = 5'd4;
  localparam logic [4:0] OP_LATCH_R    = 5'd5;
  localparam logic [4:0] OP_FRAC_START = 5'd6;
  localparam logic [4:0] OP_FRAC_FIN   = 5'd7;
  localparam logic [4:0] OP_T2         = 5'd8;
  localparam logic [4:0] OP_T3         = 5'd9;
  localparam logic [4:0] OP_BASIS      = 5'd10;
  localparam logic [4:0] OP_D10        = 5'd11;
  localparam logic [4:0] OP_D11        = 5'd12;
  localparam logic [4:0] OP_RES_ACC    = 5'd13;
  localparam logic [4:0] OP_RES_RD     = 5'd14;
  localparam logic [4:0] OP_RES_VL     = 5'd15;
  localparam logic [4:0] OP_RES_ZERO   = 5'd16;

  // Multiplier operand pairs.
  localparam logic [3:0] MS_NONE      = 4'd0;
  localparam logic [3:0] MS_VL_ONEMT  = 4'd1;
  localparam logic [3:0] MS_VR_T      = 4'd2;
  localparam logic [3:0] MS_T_T       = 4'd3;
  localparam logic [3:0] MS_T2_T      = 4'd4;
  localparam logic [3:0] MS_DUR_H10   = 4'd5;
  localparam logic [3:0] MS_DUR_H11   = 4'd6;
  localparam logic [3:0] MS_VL_H00    = 4'd7;
  localparam logic [3:0] MS_OUTL_D10  = 4'd8;
  localparam logic [3:0] MS_VR_H01    = 4'd9;
  localparam logic [3:0] MS_INR_D11   = 4'd10;

  // Accumulator operations.
  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;

  typedef struct packed {
    logic              wr_en;
    logic              capture;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [4:0]        op;
    logic [3:0]        mul_sel;
    logic [1:0]        acc_op;
    logic              out_load;
  } kce_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic wt_ge_end;
    logic wt_ge_rd;
    logic wt_le_rd;
    logic step_case;
    logic kind_lin;
  } kce_sts_t;

endpackage

`default_nettype wire

// File: hdl/keyframe_curve_evaluator_unit.sv
// Top level of the keyframe curve evaluator: port unpacking and the
// controller and datapath instances. Depends on kce_pkg, kce_ctrl, kce_dpath.
//
//  Channel   Direction  Handshake          Contents
//  in_*      slave      tvalid / tready    load or evaluate word, tuser = mode
//  out_*     master     tvalid / tready    curve value word, tuser = curve_empty
//  cfg_*     slave      valid / ready      key_count register write
//
// A load word is written straight into the key memories when it is accepted.
// An evaluate word goes, from acceptance until its result sits in the output
// register, through memory reads, the divider when loop or ping-pong wrapping
// runs it, binary search probes unless the cached segment hits, the fraction
// divider, and linear or cubic blending on the shared multiplier.
// Reset is synchronous, active low; it clears the key count and the cached segment.
// The next word is accepted while a finished result still waits in the output
// register; a stalled output only holds the block once the next result is ready.
`default_nettype none

module keyframe_curve_evaluator_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // tdata: key_index[5:0], key_time[37:6], key_value[69:38],
  // key_in_tangent[101:70], key_out_tangent[133:102], key_interp[135:134],
  // sample_time[167:136], wrap_mode[169:168], zero fill[175:170]
  input  wire logic [175:0] in_tdata,
  // tuser: mode[0]
  input  wire logic         in_tuser,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: curve_value[31:0], segment_index[37:32], zero fill[39:38]
  output logic [39:0]       out_tdata,
  // tuser: curve_empty[0]
  output logic              out_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [6:0]   cfg_data,
  input  wire logic         cfg_valid,
  output logic              cfg_ready
);
  import kce_pkg::*;

  kce_cmd_t           cmd;
  kce_sts_t           sts;
  logic signed [31:0] curve_value;
  logic [5:0]         segment_index;

  // Unpack the input word; each field keeps its declared signedness.
  logic [5:0]         key_index;
  logic signed [31:0] key_time, key_value, key_in_tangent, key_out_tangent, sample_time;
  logic [1:0]         key_interp, wrap_mode;

  assign key_index       = in_tdata[5:0];
  assign key_time        = in_tdata[37:6];
  assign key_value       = in_tdata[69:38];
  assign key_in_tangent  = in_tdata[101:70];
  assign key_out_tangent = in_tdata[133:102];
  assign key_interp      = in_tdata[135:134];
  assign sample_time     = in_tdata[167:136];
  assign wrap_mode       = in_tdata[169:168];

  assign out_tdata = {2'b00, segment_index, curve_value};

  kce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_mode   (in_tuser),
    .in_ready  (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_seg   (segment_index),
    .out_empty (out_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  kce_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .ld_addr    (key_index),
    .ld_time    (key_time),
    .ld_value   (key_value),
    .ld_in_tan  (key_in_tangent),
    .ld_out_tan (key_out_tangent),
    .ld_interp  (key_interp),
    .ev_time    (sample_time),
    .ev_wrap    (wrap_mode),
    .sts        (sts),
    .out_value  (curve_value)
  );

endmodule

`default_nettype wire

// File: hdl/kce_ctrl.sv
// Controller of the keyframe curve evaluator: handshakes, key count register,
// sequencing state machine and key search. Depends on kce_pkg.
`default_nettype none

module kce_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_mode,
  output logic                     in_ready,
  input  wire logic                cfg_valid,
  input  wire logic [6:0]          cfg_data,
  output logic                     cfg_ready,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [5:0]               out_seg,
  output logic                     out_empty,
  input  wire kce_pkg::kce_sts_t   sts,
  output kce_pkg::kce_cmd_t        cmd
);
  import kce_pkg::*;

  localparam logic [5:0] S_IDLE      = 6'd0;
  localparam logic [5:0] S_RD_FIRST  = 6'd1;
  localparam logic [5:0] S_GET_FIRST = 6'd2;
  localparam logic [5:0] S_GET_LAST  = 6'd3;
  localparam logic [5:0] S_WRAP_WAIT = 6'd4;
  localparam logic [5:0] S_CHK_END   = 6'd5;
  localparam logic [5:0] S_LAST_VAL  = 6'd6;
  localparam logic [5:0] S_CACHE_A   = 6'd7;
  localparam logic [5:0] S_CACHE_B   = 6'd8;
  localparam logic [5:0] S_BS_INIT   = 6'd9;
  localparam logic [5:0] S_BS_TEST   = 6'd10;
  localparam logic [5:0] S_BS_CMP    = 6'd11;
  localparam logic [5:0] S_BS_END    = 6'd12;
  localparam logic [5:0] S_INTERP_L  = 6'd13;
  localparam logic [5:0] S_GET_L     = 6'd14;
  localparam logic [5:0] S_GET_R     = 6'd15;
  localparam logic [5:0] S_DECIDE    = 6'd16;
  localparam logic [5:0] S_FRAC_WAIT = 6'd17;
  localparam logic [5:0] S_LIN1      = 6'd18;
  localparam logic [5:0] S_LIN2      = 6'd19;
  localparam logic [5:0] S_SUM_LAST  = 6'd20;
  localparam logic [5:0] S_ROUND     = 6'd21;
  localparam logic [5:0] S_CUB1      = 6'd22;
  localparam logic [5:0] S_CUB2      = 6'd23;
  localparam logic [5:0] S_CUB3      = 6'd24;
  localparam logic [5:0] S_CUB4      = 6'd25;
  localparam logic [5:0] S_CUB5      = 6'd26;
  localparam logic [5:0] S_CUB6      = 6'd27;
  localparam logic [5:0] S_CUB7      = 6'd28;
  localparam logic [5:0] S_CUB8      = 6'd29;
  localparam logic [5:0] S_CUB9      = 6'd30;
  localparam logic [5:0] S_CUB10     = 6'd31;
  localparam logic [5:0] S_CUB11     = 6'd32;
  localparam logic [5:0] S_FIN       = 6'd33;

  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_KEYS);

  logic [5:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  key_count_r, key_count_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] cache_r, cache_nxt;
  logic [ADDR_W-1:0] seg_r, seg_nxt;
  logic              empty_r, empty_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_seg_r, out_seg_nxt;
  logic              out_empty_r, out_empty_nxt;

  logic [CNT_W-1:0] n_cl, nm1, nm2, bs_step, bs_it, left_raw, left_cl;
  logic             accept;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_seg   = out_seg_r;
  assign out_empty = out_empty_r;

  assign n_cl     = (key_count_r > MAX_N) ? MAX_N : key_count_r;
  assign nm1      = n_r - CNT_W'(1);
  assign nm2      = n_r - CNT_W'(2);
  assign bs_step  = cnt_r >> 1;
  assign bs_it    = lo_r + bs_step;
  assign left_raw = (lo_r == '0) ? '0 : lo_r - CNT_W'(1);
  assign left_cl  = (left_raw > nm2) ? nm2 : left_raw;

  always_comb begin
    state_nxt     = state_r;
    key_count_nxt = key_count_r;
    n_nxt         = n_r;
    lo_nxt        = lo_r;
    cnt_nxt       = cnt_r;
    cache_nxt     = cache_r;
    seg_nxt       = seg_r;
    empty_nxt     = empty_r;
    out_valid_nxt = out_valid_r;
    out_seg_nxt   = out_seg_r;
    out_empty_nxt = out_empty_r;
    cmd           = '0;

    if (cfg_valid) begin
      key_count_nxt = cfg_data;
    end
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept && (in_mode == MODE_LOAD)) begin
          cmd.wr_en = 1'b1;
        end else if (accept) begin
          cmd.capture = 1'b1;
          n_nxt       = n_cl;
          seg_nxt     = '0;
          empty_nxt   = (n_cl == '0);
          if (n_cl == '0) begin
            cmd.op    = OP_RES_ZERO;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_RD_FIRST;
          end
        end
      end
      S_RD_FIRST: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_GET_FIRST;
      end
      S_GET_FIRST: begin
        cmd.op = OP_START;
        if (n_r == CNT_W'(1)) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = nm1[ADDR_W-1:0];
          state_nxt   = S_GET_LAST;
        end
      end
      S_GET_LAST: begin
        cmd.op    = OP_WRAP_SETUP;
        state_nxt = S_WRAP_WAIT;
      end
      S_WRAP_WAIT: begin
        if (!sts.div_busy) begin
          cmd.op    = OP_WRAP_FIN;
          state_nxt = S_CHK_END;
        end
      end
      S_CHK_END: begin
        if (sts.wt_ge_end) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = nm1[ADDR_W-1:0];
          state_nxt   = S_LAST_VAL;
        end else if ({1'b0, cache_r} < nm1) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = cache_r;
          state_nxt   = S_CACHE_A;
        end else begin
          state_nxt = S_BS_INIT;
        end
      end
      S_LAST_VAL: begin
        cmd.op    = OP_RES_RD;
        seg_nxt   = nm1[ADDR_W-1:0];
        state_nxt = S_FIN;
      end
      S_CACHE_A: begin
        if (sts.wt_ge_rd) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = cache_r + ADDR_W'(1);
          state_nxt   = S_CACHE_B;
        end else begin
          state_nxt = S_BS_INIT;
        end
      end
      S_CACHE_B: begin
        if (sts.wt_le_rd) begin
          seg_nxt   = cache_r;
          state_nxt = S_INTERP_L;
        end else begin
          state_nxt = S_BS_INIT;
        end
      end
      S_BS_INIT: begin
        lo_nxt    = '0;
        cnt_nxt   = n_r;
        state_nxt = S_BS_TEST;
      end
      S_BS_TEST: begin
        if (cnt_r == '0) begin
          state_nxt = S_BS_END;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = bs_it[ADDR_W-1:0];
          state_nxt   = S_BS_CMP;
        end
      end
      S_BS_CMP: begin
        if (sts.wt_ge_rd) begin
          lo_nxt  = bs_it + CNT_W'(1);
          cnt_nxt = cnt_r - bs_step - CNT_W'(1);
        end else begin
          cnt_nxt = bs_step;
        end
        state_nxt = S_BS_TEST;
      end
      S_BS_END: begin
        seg_nxt   = left_cl[ADDR_W-1:0];
        cache_nxt = left_cl[ADDR_W-1:0];
        state_nxt = S_INTERP_L;
      end
      S_INTERP_L: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = seg_r;
        state_nxt   = S_GET_L;
      end
      S_GET_L: begin
        cmd.op      = OP_LATCH_L;
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = seg_r + ADDR_W'(1);
        state_nxt   = S_GET_R;
      end
      S_GET_R: begin
        cmd.op    = OP_LATCH_R;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.step_case) begin
          cmd.op    = OP_RES_VL;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_FRAC_START;
          state_nxt = S_FRAC_WAIT;
        end
      end
      S_FRAC_WAIT: begin
        if (!sts.div_busy) begin
          cmd.op    = OP_FRAC_FIN;
          state_nxt = sts.kind_lin ? S_LIN1 : S_CUB1;
        end
      end
      S_LIN1: begin
        cmd.mul_sel = MS_VL_ONEMT;
        state_nxt   = S_LIN2;
      end
      S_LIN2: begin
        cmd.acc_op  = ACC_LOAD;
        cmd.mul_sel = MS_VR_T;
        state_nxt   = S_SUM_LAST;
      end
      S_SUM_LAST: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = S_ROUND;
      end
      S_ROUND: begin
        cmd.op    = OP_RES_ACC;
        state_nxt = S_FIN;
      end
      S_CUB1: begin
        cmd.mul_sel = MS_T_T;
        state_nxt   = S_CUB2;
      end
      S_CUB2: begin
        cmd.op    = OP_T2;
        state_nxt = S_CUB3;
      end
      S_CUB3: begin
        cmd.mul_sel = MS_T2_T;
        state_nxt   = S_CUB4;
      end
      S_CUB4: begin
        cmd.op    = OP_T3;
        state_nxt = S_CUB5;
      end
      S_CUB5: begin
        cmd.op    = OP_BASIS;
        state_nxt = S_CUB6;
      end
      S_CUB6: begin
        cmd.mul_sel = MS_DUR_H10;
        state_nxt   = S_CUB7;
      end
      S_CUB7: begin
        cmd.op      = OP_D10;
        cmd.mul_sel = MS_DUR_H11;
        state_nxt   = S_CUB8;
      end
      S_CUB8: begin
        cmd.op      = OP_D11;
        cmd.mul_sel = MS_VL_H00;
        state_nxt   = S_CUB9;
      end
      S_CUB9: begin
        cmd.acc_op  = ACC_LOAD;
        cmd.mul_sel = MS_OUTL_D10;
        state_nxt   = S_CUB10;
      end
      S_CUB10: begin
        cmd.acc_op  = ACC_ADD;
        cmd.mul_sel = MS_VR_H01;
        state_nxt   = S_CUB11;
      end
      S_CUB11: begin
        cmd.acc_op  = ACC_ADD;
        cmd.mul_sel = MS_INR_D11;
        state_nxt   = S_SUM_LAST;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          out_seg_nxt   = seg_r;
          out_empty_nxt = empty_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_count_r <= '0;
      n_r         <= '0;
      lo_r        <= '0;
      cnt_r       <= '0;
      cache_r     <= '0;
      seg_r       <= '0;
      empty_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_seg_r   <= '0;
      out_empty_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_count_r <= key_count_nxt;
      n_r         <= n_nxt;
      lo_r        <= lo_nxt;
      cnt_r       <= cnt_nxt;
      cache_r     <= cache_nxt;
      seg_r       <= seg_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
      out_seg_r   <= out_seg_nxt;
      out_empty_r <= out_empty_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/kce_dpath.sv
// Datapath of the keyframe curve evaluator: key memories, wrap and fraction
// divider, shared multiplier, accumulator and result register. Uses kce_pkg.
`default_nettype none

module kce_dpath (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire kce_pkg::kce_cmd_t        cmd,
  input  wire logic [5:0]               ld_addr,
  input  wire logic signed [31:0]       ld_time,
  input  wire logic signed [31:0]       ld_value,
  input  wire logic signed [31:0]       ld_in_tan,
  input  wire logic signed [31:0]       ld_out_tan,
  input  wire logic [1:0]               ld_interp,
  input  wire logic signed [31:0]       ev_time,
  input  wire logic [1:0]               ev_wrap,
  output kce_pkg::kce_sts_t             sts,
  output logic signed [31:0]            out_value
);
  import kce_pkg::*;

  localparam int TW = FRAC_BITS + 1;
  localparam int HW = FRAC_BITS + 4;
  localparam logic signed [66:0] HALF_P = 67'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [67:0] HALF_A = 68'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [66:0] DH_HI  = 67'sd1610612736;
  localparam logic signed [66:0] DH_LO  = -67'sd1610612736;
  localparam logic signed [67:0] SAT_HI = 68'sd2147483647;
  localparam logic signed [67:0] SAT_LO = -68'sd2147483648;
  localparam logic [DCNT_W-1:0]  WRAP_ITERS = DCNT_W'(33);
  localparam logic [DCNT_W-1:0]  FRAC_ITERS = DCNT_W'(FRAC_BITS);

  logic [31:0] time_mem   [MAX_KEYS];
  logic [31:0] value_mem  [MAX_KEYS];
  logic [31:0] in_mem     [MAX_KEYS];
  logic [31:0] out_mem    [MAX_KEYS];
  logic [1:0]  interp_mem [MAX_KEYS];

  logic signed [31:0] rd_time_r, rd_value_r, rd_in_r, rd_out_r;
  logic [1:0]         rd_interp_r;

  logic signed [31:0] samp_r, start_r, end_r, wt_r, res_r, out_value_r;
  logic [1:0]         wm_r;
  logic [32:0]        len_r;
  logic               pp_r, dneg_r, wdiv_r, fdiv_r;
  logic signed [31:0] vl_r, vr_r, outl_r, inr_r, tl_r, d10_r, d11_r;
  logic [1:0]         kind_r;
  logic signed [32:0] dur_r, diff_r;
  logic [TW-1:0]      t_r, t2_r, t3_r;
  logic signed [HW-1:0] h00_r, h10_r, h01_r, h11_r;
  logic signed [66:0] prod_r;
  logic signed [67:0] acc_r;

  // Restoring divider, one quotient bit per cycle.
  logic [33:0]          dv_rem_r, dv_div_r;
  logic [32:0]          dv_dvd_r;
  logic [FRAC_BITS-1:0] dv_q_r;
  logic [DCNT_W-1:0]    dv_cnt_r;
  logic                 dv_busy_r;
  logic [34:0]          dv_sh, dv_sub;
  logic                 dv_ge;
  logic                 dv_start;
  logic [33:0]          dv_rem_init, dv_div_init;
  logic [32:0]          dv_dvd_init;
  logic [DCNT_W-1:0]    dv_cnt_init;

  // Wrap arithmetic.
  logic signed [32:0] w_len, w_d;
  logic               w_clamp;
  logic [32:0]        w_abs;
  logic signed [31:0] w_cl1, w_cl2;
  logic [33:0]        f_off1, f_off;

  logic               fr_neg, fr_ge;
  logic signed [33:0] ma;
  logic signed [32:0] mb;
  logic signed [66:0] rs_prod;
  logic signed [67:0] rs_acc;
  logic signed [HW-1:0] te, t2e, t3e, onee;
  logic signed [31:0] d_clamped;

  assign out_value = out_value_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      time_mem[ld_addr]   <= ld_time;
      value_mem[ld_addr]  <= ld_value;
      in_mem[ld_addr]     <= ld_in_tan;
      out_mem[ld_addr]    <= ld_out_tan;
      interp_mem[ld_addr] <= ld_interp;
    end
    if (cmd.rd_en) begin
      rd_time_r   <= time_mem[cmd.rd_addr];
      rd_value_r  <= value_mem[cmd.rd_addr];
      rd_in_r     <= in_mem[cmd.rd_addr];
      rd_out_r    <= out_mem[cmd.rd_addr];
      rd_interp_r <= interp_mem[cmd.rd_addr];
    end
  end

  assign w_len   = {rd_time_r[31], rd_time_r} - {start_r[31], start_r};
  assign w_d     = {samp_r[31], samp_r} - {start_r[31], start_r};
  assign w_clamp = (w_len <= 33'sd0) || !((wm_r == WRAP_LOOP) || (wm_r == WRAP_PING));
  assign w_abs   = w_d[32] ? 33'(-w_d) : 33'(w_d);
  assign w_cl1   = (samp_r < start_r) ? start_r : samp_r;
  assign w_cl2   = (w_cl1 > rd_time_r) ? rd_time_r : w_cl1;

  // Floor remainder, then fold the back half of a ping-pong period.
  assign f_off1 = (dneg_r && (dv_rem_r != '0)) ? dv_div_r - dv_rem_r : dv_rem_r;
  assign f_off  = (pp_r && (f_off1 > {1'b0, len_r})) ? dv_div_r - f_off1 : f_off1;

  assign fr_neg = diff_r < 33'sd0;
  assign fr_ge  = diff_r >= dur_r;

  always_comb begin
    dv_start    = 1'b0;
    dv_rem_init = '0;
    dv_dvd_init = '0;
    dv_div_init = '0;
    dv_cnt_init = '0;
    case (cmd.op)
      OP_WRAP_SETUP: begin
        dv_start    = !w_clamp;
        dv_dvd_init = w_abs;
        dv_div_init = (wm_r == WRAP_LOOP) ? {1'b0, w_len} : {w_len, 1'b0};
        dv_cnt_init = WRAP_ITERS;
      end
      OP_FRAC_START: begin
        dv_start    = !fr_neg && !fr_ge;
        dv_rem_init = {1'b0, diff_r};
        dv_div_init = {1'b0, dur_r};
        dv_cnt_init = FRAC_ITERS;
      end
      default: begin
        dv_start = 1'b0;
      end
    endcase
  end

  assign dv_sh  = {dv_rem_r, dv_dvd_r[32]};
  assign dv_ge  = dv_sh >= {1'b0, dv_div_r};
  assign dv_sub = dv_sh - {1'b0, dv_div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
    end else if (dv_start) begin
      dv_busy_r <= 1'b1;
    end else if (dv_busy_r && (dv_cnt_r == DCNT_W'(1))) begin
      dv_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_start) begin
      dv_rem_r <= dv_rem_init;
      dv_dvd_r <= dv_dvd_init;
      dv_div_r <= dv_div_init;
      dv_cnt_r <= dv_cnt_init;
      dv_q_r   <= '0;
    end else if (dv_busy_r) begin
      dv_rem_r <= dv_ge ? dv_sub[33:0] : dv_sh[33:0];
      dv_dvd_r <= {dv_dvd_r[31:0], 1'b0};
      dv_q_r   <= {dv_q_r[FRAC_BITS-2:0], dv_ge};
      dv_cnt_r <= dv_cnt_r - DCNT_W'(1);
    end
  end

  // Shared multiplier operands.
  always_comb begin
    case (cmd.mul_sel)
      MS_VL_ONEMT: begin
        ma = {{2{vl_r[31]}}, vl_r};
        mb = 33'({1'b0, ONE_Q - t_r});
      end
      MS_VR_T: begin
        ma = {{2{vr_r[31]}}, vr_r};
        mb = 33'({1'b0, t_r});
      end
      MS_T_T: begin
        ma = 34'({1'b0, t_r});
        mb = 33'({1'b0, t_r});
      end
      MS_T2_T: begin
        ma = 34'({1'b0, t2_r});
        mb = 33'({1'b0, t_r});
      end
      MS_DUR_H10: begin
        ma = {dur_r[32], dur_r};
        mb = 33'(h10_r);
      end
      MS_DUR_H11: begin
        ma = {dur_r[32], dur_r};
        mb = 33'(h11_r);
      end
      MS_VL_H00: begin
        ma = {{2{vl_r[31]}}, vl_r};
        mb = 33'(h00_r);
      end
      MS_OUTL_D10: begin
        ma = {{2{outl_r[31]}}, outl_r};
        mb = {d10_r[31], d10_r};
      end
      MS_VR_H01: begin
        ma = {{2{vr_r[31]}}, vr_r};
        mb = 33'(h01_r);
      end
      MS_INR_D11: begin
        ma = {{2{inr_r[31]}}, inr_r};
        mb = {d11_r[31], d11_r};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign rs_prod = (prod_r + HALF_P) >>> FRAC_BITS;
  assign rs_acc  = (acc_r + HALF_A) >>> FRAC_BITS;
  assign te      = HW'({1'b0, t_r});
  assign t2e     = HW'({1'b0, t2_r});
  assign t3e     = HW'({1'b0, t3_r});
  assign onee    = HW'({1'b0, ONE_Q});
  assign d_clamped = (rs_prod > DH_HI) ? DH_HI[31:0] :
                     (rs_prod < DH_LO) ? DH_LO[31:0] : rs_prod[31:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != MS_NONE) begin
      prod_r <= ma * mb;
    end
    case (cmd.acc_op)
      ACC_LOAD: acc_r <= {prod_r[66], prod_r};
      ACC_ADD:  acc_r <= acc_r + {prod_r[66], prod_r};
      default:  acc_r <= acc_r;
    endcase
    if (cmd.capture) begin
      samp_r <= ev_time;
      wm_r   <= ev_wrap;
    end
    if (cmd.out_load) begin
      out_value_r <= res_r;
    end
    case (cmd.op)
      OP_START: begin
        start_r <= rd_time_r;
        res_r   <= rd_value_r;
      end
      OP_WRAP_SETUP: begin
        end_r  <= rd_time_r;
        len_r  <= w_len;
        pp_r   <= (wm_r == WRAP_PING);
        dneg_r <= w_d[32];
        if (w_clamp) begin
          wt_r <= w_cl2;
        end
      end
      OP_WRAP_FIN: begin
        if (wdiv_r) begin
          wt_r <= start_r + f_off[31:0];
        end
      end
      OP_LATCH_L: begin
        tl_r   <= rd_time_r;
        vl_r   <= rd_value_r;
        outl_r <= rd_out_r;
        kind_r <= rd_interp_r;
      end
      OP_LATCH_R: begin
        vr_r   <= rd_value_r;
        inr_r  <= rd_in_r;
        dur_r  <= {rd_time_r[31], rd_time_r} - {tl_r[31], tl_r};
        diff_r <= {wt_r[31], wt_r} - {tl_r[31], tl_r};
      end
      OP_FRAC_START: begin
        if (fr_neg) begin
          t_r <= '0;
        end else if (fr_ge) begin
          t_r <= ONE_Q;
        end
      end
      OP_FRAC_FIN: begin
        if (fdiv_r) begin
          t_r <= {1'b0, dv_q_r};
        end
      end
      OP_T2: t2_r <= rs_prod[TW-1:0];
      OP_T3: t3_r <= rs_prod[TW-1:0];
      OP_BASIS: begin
        h00_r <= (t3e <<< 1) - ((t2e <<< 1) + t2e) + onee;
        h10_r <= t3e - (t2e <<< 1) + te;
        h01_r <= ((t2e <<< 1) + t2e) - (t3e <<< 1);
        h11_r <= t3e - t2e;
      end
      OP_D10: d10_r <= d_clamped;
      OP_D11: d11_r <= d_clamped;
      OP_RES_ACC: begin
        res_r <= (rs_acc > SAT_HI) ? SAT_HI[31:0] :
                 (rs_acc < SAT_LO) ? SAT_LO[31:0] : rs_acc[31:0];
      end
      OP_RES_RD:   res_r <= rd_value_r;
      OP_RES_VL:   res_r <= vl_r;
      OP_RES_ZERO: res_r <= '0;
      default: begin
        res_r <= res_r;
      end
    endcase
  end

  // Remember which waits actually ran a division.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wdiv_r <= 1'b0;
      fdiv_r <= 1'b0;
    end else begin
      if (cmd.op == OP_WRAP_SETUP) begin
        wdiv_r <= !w_clamp;
      end
      if (cmd.op == OP_FRAC_START) begin
        fdiv_r <= !fr_neg && !fr_ge;
      end
    end
  end

  assign sts.div_busy  = dv_busy_r;
  assign sts.wt_ge_end = wt_r >= end_r;
  assign sts.wt_ge_rd  = wt_r >= rd_time_r;
  assign sts.wt_le_rd  = wt_r <= rd_time_r;
  assign sts.step_case = (dur_r <= 33'sd0) || (kind_r == KIND_STEP);
  assign sts.kind_lin  = (kind_r == KIND_LINEAR);

endmodule

`default_nettype wire

// File: hdl/kce_checker.sv
// Port-level checker of the keyframe curve evaluator and its bind statement.
// Depends on assert_macros.svh and the top-level port list.
`default_nettype none
`include "assert_macros.svh"

module kce_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic [175:0] in_tdata,
  input wire logic         in_tuser,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [39:0]  out_tdata,
  input wire logic         out_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [6:0]   cfg_data,
  input wire logic         cfg_valid,
  input wire logic         cfg_ready
);

  // A result word stays offered until it is taken.
  `ASSERT_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "output word dropped while stalled")

  // An empty table reports a zero value from segment zero.
  `ASSERT_CLK(a_empty_zero, out_tvalid && out_tuser |-> out_tdata[37:0] == 38'd0, "empty result not zero")

  // An evaluate word keeps the input closed on the following cycle.
  `ASSERT_CLK(a_eval_busy, in_tvalid && in_tready && in_tuser |=> !in_tready, "input open during evaluation")

  // Reset leaves no result pending.
  `ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_tvalid, "result pending after reset")

endmodule

bind keyframe_curve_evaluator_unit kce_checker u_kce_checker (.*);

`default_nettype wire

// File: bench/keyframe_curve_evaluator_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for keyframe_curve_evaluator_unit: loads key tables,
// sweeps key_count and wrap modes, and checks each curve word against a
// predictor kept in the bench. Depends on kce_pkg and the block's RTL.

module keyframe_curve_evaluator_unit_tb;
  import kce_pkg::*;

  // Codes the package does not name.
  localparam logic [1:0] KIND_CUBIC = 2'd2;
  localparam logic [1:0] KIND_ALT   = 2'd3;
  localparam logic [1:0] WRAP_CLAMP = 2'd0;
  localparam logic [1:0] WRAP_ALT   = 2'd3;
  localparam logic [6:0] CNT_MAX    = 7'd127;

  localparam longint Q_ONE    = 64'sd65536;
  localparam longint TAN_LIM  = 64'sd3 << 29;
  localparam longint INT_MIN  = -64'sd2147483648;
  localparam longint INT_MAX  = 64'sd2147483647;
  localparam int     SETTLE   = 130;   // beyond the slowest evaluate word

  typedef struct {
    logic [31:0] value;
    logic [5:0]  seg;
    logic        empty;
  } curve_word_t;

  logic         clk;
  logic         rst_n;
  logic [175:0] in_tdata;
  logic         in_tuser;
  logic         in_tvalid;
  logic         in_tready;
  logic [39:0]  out_tdata;
  logic         out_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [6:0]   cfg_data;
  logic         cfg_valid;
  logic         cfg_ready;

  // Shadow copy of the block's key table, count and segment cache.
  logic [31:0] key_t   [MAX_KEYS];
  logic [31:0] key_v   [MAX_KEYS];
  logic [31:0] key_tin [MAX_KEYS];
  logic [31:0] key_tout[MAX_KEYS];
  logic [1:0]  key_k   [MAX_KEYS];
  logic [6:0]  key_count;
  int          seg_cache;

  curve_word_t pending_curves[$];
  int          failures;
  int          loads_sent;
  int          evals_sent;
  int          curves_seen;
  int          table_sets;
  bit          calm;   // no idling in the closing part of the run

  keyframe_curve_evaluator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Times are kept exact in 64 bits; arithmetic shift gives the
  // floor that the rounding rule wants.
  // ---------------------------------------------------------------------------
  function automatic longint sx(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint rnd_q(longint x);
    return (x + (Q_ONE >>> 1)) >>> 16;
  endfunction

  function automatic longint lim(longint x, longint lo, longint hi);
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    return x;
  endfunction

  // Left key of the segment holding tm: cached segment first, then the search.
  function automatic int locate_segment(longint tm, int n);
    int lo;
    int cnt;
    int half;
    int left;
    lo = 0;
    cnt = n;
    if (seg_cache < n - 1 && tm >= sx(key_t[seg_cache]) && tm <= sx(key_t[seg_cache + 1]))
      return seg_cache;
    while (cnt > 0) begin
      half = cnt / 2;
      if (!(tm < sx(key_t[lo + half]))) begin
        lo = lo + half + 1;
        cnt = cnt - half - 1;
      end else begin
        cnt = half;
      end
    end
    left = (lo == 0) ? 0 : lo - 1;
    if (left > n - 2) left = n - 2;
    seg_cache = left;
    return left;
  endfunction

  function automatic longint blend_segment(int l, longint tm);
    longint dur, vl, vr, t, t2, t3, h00, h10, h01, h11, d10, d11, acc;
    dur = sx(key_t[l + 1]) - sx(key_t[l]);
    vl = sx(key_v[l]);
    vr = sx(key_v[l + 1]);
    if (dur <= 0 || key_k[l] == KIND_STEP) return vl;
    t = lim(((tm - sx(key_t[l])) * Q_ONE) / dur, 0, Q_ONE);
    if (key_k[l] == KIND_LINEAR) return rnd_q(vl * (Q_ONE - t) + vr * t);
    // Cubic Hermite; the unused kind code behaves the same way.
    t2 = rnd_q(t * t);
    t3 = rnd_q(t2 * t);
    h00 = 2 * t3 - 3 * t2 + Q_ONE;
    h10 = t3 - 2 * t2 + t;
    h01 = -2 * t3 + 3 * t2;
    h11 = t3 - t2;
    d10 = lim(rnd_q(dur * h10), -TAN_LIM, TAN_LIM);
    d11 = lim(rnd_q(dur * h11), -TAN_LIM, TAN_LIM);
    acc = vl * h00 + sx(key_tout[l]) * d10 + vr * h01 + sx(key_tin[l + 1]) * d11;
    return rnd_q(acc);
  endfunction

  function automatic curve_word_t predict_curve(logic [31:0] sample, logic [1:0] wm);
    curve_word_t r;
    int     n;
    int     seg;
    longint tm, t0, t1, span, off, period, val;
    n = (key_count > MAX_KEYS) ? MAX_KEYS : key_count;
    val = 0;
    seg = 0;
    r.empty = 1'b0;
    if (n == 0) begin
      r.empty = 1'b1;
    end else if (n == 1) begin
      val = sx(key_v[0]);
    end else begin
      t0 = sx(key_t[0]);
      t1 = sx(key_t[n - 1]);
      tm = sx(sample);
      span = t1 - t0;
      if (span <= 0 || (wm != WRAP_LOOP && wm != WRAP_PING)) begin
        tm = lim(tm, t0, t1);
      end else if (wm == WRAP_LOOP) begin
        off = (tm - t0) % span;
        if (off < 0) off += span;
        tm = t0 + off;
      end else begin
        period = 2 * span;
        off = (tm - t0) % period;
        if (off < 0) off += period;
        if (off > span) off = period - off;
        tm = t0 + off;
      end
      if (tm >= t1) begin
        // Past the last key: hold it, and the cache stays as it is.
        val = sx(key_v[n - 1]);
        seg = n - 1;
      end else begin
        seg = locate_segment(tm, n);
        val = blend_segment(seg, tm);
      end
    end
    r.value = 32'(lim(val, INT_MIN, INT_MAX));
    r.seg = 6'(seg);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sends one input word and, once it is taken, updates the shadow state.
  task automatic send_word(logic mode, logic [5:0] idx, logic [31:0] kt, logic [31:0] kv,
                           logic [31:0] kin, logic [31:0] kout, logic [1:0] kind,
                           logic [31:0] sample, logic [1:0] wm);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {6'd0, wm, sample, kind, kout, kin, kv, kt, idx};
    do @(posedge clk); while (!in_tready);
    if (mode == MODE_LOAD) begin
      key_t[idx] = kt;
      key_v[idx] = kv;
      key_tin[idx] = kin;
      key_tout[idx] = kout;
      key_k[idx] = kind;
      loads_sent++;
    end else begin
      pending_curves.insert(pending_curves.size(), predict_curve(sample, wm));
      evals_sent++;
    end
  endtask

  task automatic load_key(int idx, longint kt, longint kv, longint kin, longint kout,
                          logic [1:0] kind);
    send_word(MODE_LOAD, 6'(idx), 32'(kt), 32'(kv), 32'(kin), 32'(kout), kind,
              $urandom, 2'($urandom));
  endtask

  task automatic eval_at(longint sample, logic [1:0] wm);
    send_word(MODE_EVAL, 6'($urandom), $urandom, $urandom, $urandom, $urandom,
              2'($urandom), 32'(sample), wm);
  endtask

  // Lets every outstanding word drain before the register changes.
  task automatic drain;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_curves.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_key_count(logic [6:0] cnt);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= cnt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    key_count = cnt;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    failures++;
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: every curve word taken is matched against the oldest
  // prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    curve_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      curves_seen++;
      if (pending_curves.size() == 0) begin
        report_mismatch("unexpected curve word", out_tdata[31:0], 32'd0);
      end else begin
        want = pending_curves.pop_front();
        if (out_tdata[31:0] !== want.value)
          report_mismatch("curve_value", out_tdata[31:0], want.value);
        if (out_tdata[37:32] !== want.seg)
          report_mismatch("segment_index", 32'(out_tdata[37:32]), 32'(want.seg));
        if (out_tuser !== want.empty)
          report_mismatch("curve_empty", 32'(out_tuser), 32'(want.empty));
      end
    end
  end

  // Output back-pressure in random bursts; always ready once the run is calm.
  initial begin
    out_tready = 1'b1;
    forever begin
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Reset leaves no keys, so the first word reports an empty curve.
  task automatic test_empty_and_single;
    eval_at(0, WRAP_CLAMP);
    load_key(0, 64'sh1_0000, INT_MAX, 0, 0, KIND_LINEAR);
    write_key_count(7'd1);
    eval_at(-64'sh5_0000, WRAP_LOOP);
  endtask

  // One segment of each kind, probed mid-segment and outside the span.
  task automatic test_segment_kinds;
    load_key(0, 64'sh1_0000, 64'sh10_0000, 64'sh2_0000, -64'sh2_0000, KIND_STEP);
    load_key(1, 64'sh2_0000, 64'sh20_0000, 64'sh1_0000, 64'sh3_0000, KIND_LINEAR);
    load_key(2, 64'sh3_0000, -64'sh8_0000, -64'sh4_0000, 64'sh4_0000, KIND_CUBIC);
    load_key(3, 64'sh4_0000, 64'sh4_0000, 64'sh5_0000, -64'sh6_0000, KIND_ALT);
    load_key(4, 64'sh5_0000, 64'sh30_0000, 64'sh1_8000, 0, KIND_LINEAR);
    write_key_count(7'd5);
    eval_at(64'sh1_8000, WRAP_CLAMP);
    eval_at(64'sh2_4000, WRAP_CLAMP);
    eval_at(64'sh3_C000, WRAP_CLAMP);
    eval_at(64'sh4_8000, WRAP_CLAMP);
    eval_at(64'sh5_0000, WRAP_CLAMP);
    eval_at(64'sh0_8000, WRAP_CLAMP);
  endtask

  // Loop, ping-pong and the spare wrap code; then a span of zero length.
  task automatic test_wrap_modes;
    eval_at(64'sh9_8000, WRAP_LOOP);
    eval_at(-64'sh7_4000, WRAP_PING);
    eval_at(64'sh8_2000, WRAP_ALT);
    load_key(1, 64'sh1_0000, 64'sh20_0000, 0, 0, KIND_LINEAR);
    write_key_count(7'd2);
    eval_at(64'sh3_0000, WRAP_LOOP);
  endtask

  // Full-range times, values and tangents across one long cubic segment.
  task automatic test_extremes;
    load_key(0, INT_MIN, INT_MIN, INT_MAX, INT_MAX, KIND_CUBIC);
    load_key(1, INT_MAX, INT_MAX, INT_MIN, INT_MIN, KIND_CUBIC);
    eval_at(INT_MIN, WRAP_PING);
    eval_at(INT_MAX, WRAP_LOOP);
    eval_at(64'sh1234_5678, WRAP_PING);
  endtask

  // ---------------------------------------------------------------------------
  // Random tables, each loaded in full and then sampled over and around its span.
  // ---------------------------------------------------------------------------
  task automatic test_random_tables;
    int     n;
    int     evals;
    longint kt;
    longint stride;
    longint t0;
    longint span;
    longint sample;
    bit     shuffled;
    while (loads_sent + evals_sent < 1200) begin
      if (loads_sent + evals_sent > 1000) calm = 1'b1;
      n = ($urandom_range(0, 9) == 0) ? MAX_KEYS : $urandom_range(2, 8);
      shuffled = ($urandom_range(0, 9) == 0);
      stride = ($urandom_range(0, 2) == 0) ? (64'sd3 << 30) / n : 64'sd1 << 18;
      kt = INT_MIN + longint'($urandom_range(0, 32'h7FFF_FFFF)) +
           (($urandom_range(0, 1) == 1) ? 0 : 64'sh4000_0000);
      if (kt + stride * n > INT_MAX) kt = INT_MIN;
      for (int i = 0; i < n; i++) begin
        load_key(i, shuffled ? sx($urandom) : kt, sx($urandom), sx($urandom),
                 sx($urandom), 2'($urandom));
        if ($urandom_range(0, 7) != 0)
          kt += 1 + longint'($urandom) % stride;
      end
      if (n == MAX_KEYS && $urandom_range(0, 2) == 0)
        write_key_count(($urandom_range(0, 1) == 1) ? CNT_MAX : 7'd65);
      else
        write_key_count(7'(n));
      table_sets++;
      t0 = sx(key_t[0]);
      span = sx(key_t[n - 1]) - t0;
      if (span < 4) span = 4;
      evals = $urandom_range(10, 40);
      for (int j = 0; j < evals; j++) begin
        case ($urandom_range(0, 9))
          0:       sample = sx($urandom);
          1:       sample = sx(key_t[$urandom_range(0, n - 1)]);
          2: begin
            // A reload mid-run; the table may end up out of order.
            load_key($urandom_range(0, n - 1), sx($urandom), sx($urandom), sx($urandom),
                     sx($urandom), 2'($urandom));
            sample = t0;
          end
          default: sample = t0 - span / 4 + longint'($urandom) % (span + span / 2);
        endcase
        eval_at(lim(sample, INT_MIN, INT_MAX), 2'($urandom));
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = MODE_LOAD;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    calm      = 1'b0;
    failures  = 0;
    loads_sent = 0;
    evals_sent = 0;
    curves_seen = 0;
    table_sets = 0;
    key_count = '0;
    seg_cache = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_single();
    test_segment_kinds();
    test_wrap_modes();
    test_extremes();
    test_random_tables();
    drain();

    $display("Covered %0d key loads and %0d evaluations over %0d random tables;",
             loads_sent, evals_sent, table_sets);
    $display("%0d curve words checked, key_count from 0 up to 127.", curves_seen);
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Timeout: %0d curve words still expected", pending_curves.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
